// ===== rtl/mlr_pkg.sv =====
// shared types and constants for the midpoint line rasterizer
`default_nettype none

package mlr_pkg;

    localparam int unsigned COLOR_BITS = 8;
    localparam logic [COLOR_BITS-1:0] COLOR_RESET = 8'd200;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // per-item control carried from the setup stage to the step stage
    typedef struct packed {
        logic is_load;
        logic x_is_major;
        logic minor_neg;
        logic active;
    } mlr_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/midpoint_line_rasterizer.sv =====
// top level of the midpoint line rasterizer: colour register and the two stages
// each accepted item passes through the setup register and then the result register to the m_ side
// throughput: one item per clock while m_ready does not stall; the line state is updated
// in the same cycle as the result register, so a step may follow a load at once
// reset: synchronous, active low; no line is active and the colour returns to 200
`default_nettype none

module midpoint_line_rasterizer
    import mlr_pkg::*;
#(
    parameter int unsigned COORD_BITS = 10
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [COLOR_BITS-1:0] cfg_pixel_color,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire                   s_mode,
    input  wire  [COORD_BITS-1:0] s_start_x,
    input  wire  [COORD_BITS-1:0] s_start_y,
    input  wire  [COORD_BITS-1:0] s_end_x,
    input  wire  [COORD_BITS-1:0] s_end_y,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic [COLOR_BITS-1:0] m_color,
    output logic                  m_pixel_valid,
    output logic                  m_last
);

    logic [COLOR_BITS-1:0]   color_reg;

    logic                    q_valid;
    logic                    q_ready;
    mlr_ctl_t                q_ctl;
    logic [COORD_BITS-1:0]   q_x;
    logic [COORD_BITS-1:0]   q_y;
    logic [COORD_BITS-1:0]   q_major_end;
    logic [COORD_BITS+3:0]   q_decision;
    logic [COORD_BITS+3:0]   q_inc_straight;
    logic [COORD_BITS+3:0]   q_inc_diagonal;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= COLOR_RESET;
        end else if (cfg_valid) begin
            color_reg <= cfg_pixel_color;
        end
    end

    mlr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .s_end_x        (s_end_x),
        .s_end_y        (s_end_y),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_ctl          (q_ctl),
        .q_x            (q_x),
        .q_y            (q_y),
        .q_major_end    (q_major_end),
        .q_decision     (q_decision),
        .q_inc_straight (q_inc_straight),
        .q_inc_diagonal (q_inc_diagonal)
    );

    mlr_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_ctl          (q_ctl),
        .q_x            (q_x),
        .q_y            (q_y),
        .q_major_end    (q_major_end),
        .q_decision     (q_decision),
        .q_inc_straight (q_inc_straight),
        .q_inc_diagonal (q_inc_diagonal),
        .pixel_color    (color_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_color        (m_color),
        .m_pixel_valid  (m_pixel_valid),
        .m_last         (m_last)
    );

endmodule

`default_nettype wire

// ===== rtl/mlr_setup.sv =====
// input register stage: orders the endpoints and sets up the decision terms of a load
`default_nettype none

module mlr_setup
    import mlr_pkg::*;
#(
    parameter int unsigned COORD_BITS = 10
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire                   s_mode,
    input  wire  [COORD_BITS-1:0] s_start_x,
    input  wire  [COORD_BITS-1:0] s_start_y,
    input  wire  [COORD_BITS-1:0] s_end_x,
    input  wire  [COORD_BITS-1:0] s_end_y,
    output logic                  q_valid,
    input  wire                   q_ready,
    output mlr_ctl_t              q_ctl,
    output logic [COORD_BITS-1:0] q_x,
    output logic [COORD_BITS-1:0] q_y,
    output logic [COORD_BITS-1:0] q_major_end,
    output logic [COORD_BITS+3:0] q_decision,
    output logic [COORD_BITS+3:0] q_inc_straight,
    output logic [COORD_BITS+3:0] q_inc_diagonal
);

    localparam int unsigned N = COORD_BITS;
    localparam int unsigned D = COORD_BITS + 4;

    logic            valid_reg;
    mlr_ctl_t        ctl_reg;
    logic [N-1:0]    x_reg;
    logic [N-1:0]    y_reg;
    logic [N-1:0]    major_end_reg;
    logic [D-1:0]    decision_reg;
    logic [D-1:0]    inc_straight_reg;
    logic [D-1:0]    inc_diagonal_reg;

    logic [N:0]      dx;
    logic [N:0]      dy;
    logic [N:0]      dx_abs_w;
    logic [N:0]      dy_abs_w;
    logic [N-1:0]    adx;
    logic [N-1:0]    ady;
    logic            x_major;
    logic            swap;
    logic [N-1:0]    osx;
    logic [N-1:0]    osy;
    logic [N-1:0]    oex;
    logic [N-1:0]    oey;
    logic [N-1:0]    dmaj;
    logic [N-1:0]    dmin;
    logic [D-1:0]    dmin2;
    logic            accept;
    mlr_ctl_t        ctl_next;
    logic [N-1:0]    major_end_next;
    logic [D-1:0]    decision_next;
    logic [D-1:0]    inc_diagonal_next;

    assign s_ready = !valid_reg || q_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        dx       = {1'b0, s_end_x} - {1'b0, s_start_x};
        dy       = {1'b0, s_end_y} - {1'b0, s_start_y};
        dx_abs_w = dx[N] ? (~dx + {{N{1'b0}}, 1'b1}) : dx;
        dy_abs_w = dy[N] ? (~dy + {{N{1'b0}}, 1'b1}) : dy;
        adx      = dx_abs_w[N-1:0];
        ady      = dy_abs_w[N-1:0];
        // ties go to x
        x_major  = adx >= ady;
        swap     = x_major ? (s_start_x > s_end_x) : (s_start_y > s_end_y);
        osx      = swap ? s_end_x : s_start_x;
        osy      = swap ? s_end_y : s_start_y;
        oex      = swap ? s_start_x : s_end_x;
        oey      = swap ? s_start_y : s_end_y;
        dmaj     = x_major ? adx : ady;
        dmin     = x_major ? ady : adx;
        dmin2    = {3'b000, dmin, 1'b0};

        major_end_next    = x_major ? oex : oey;
        decision_next     = dmin2 - {4'b0000, dmaj};
        inc_diagonal_next = dmin2 - {3'b000, dmaj, 1'b0};

        ctl_next.is_load    = (s_mode == MODE_LOAD);
        ctl_next.x_is_major = x_major;
        ctl_next.minor_neg  = x_major ? (oey < osy) : (oex < osx);
        ctl_next.active     = (dmaj != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ctl_reg          <= ctl_next;
            x_reg            <= osx;
            y_reg            <= osy;
            major_end_reg    <= major_end_next;
            decision_reg     <= decision_next;
            inc_straight_reg <= dmin2;
            inc_diagonal_reg <= inc_diagonal_next;
        end
    end

    assign q_valid        = valid_reg;
    assign q_ctl          = ctl_reg;
    assign q_x            = x_reg;
    assign q_y            = y_reg;
    assign q_major_end    = major_end_reg;
    assign q_decision     = decision_reg;
    assign q_inc_straight = inc_straight_reg;
    assign q_inc_diagonal = inc_diagonal_reg;

endmodule

`default_nettype wire

// ===== rtl/mlr_step.sv =====
// line state, one midpoint step per item and the result register
`default_nettype none

module mlr_step
    import mlr_pkg::*;
#(
    parameter int unsigned COORD_BITS = 10
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   q_valid,
    output logic                  q_ready,
    input  mlr_ctl_t              q_ctl,
    input  wire  [COORD_BITS-1:0] q_x,
    input  wire  [COORD_BITS-1:0] q_y,
    input  wire  [COORD_BITS-1:0] q_major_end,
    input  wire  [COORD_BITS+3:0] q_decision,
    input  wire  [COORD_BITS+3:0] q_inc_straight,
    input  wire  [COORD_BITS+3:0] q_inc_diagonal,
    input  wire  [COLOR_BITS-1:0] pixel_color,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [COORD_BITS-1:0] m_pixel_x,
    output logic [COORD_BITS-1:0] m_pixel_y,
    output logic [COLOR_BITS-1:0] m_color,
    output logic                  m_pixel_valid,
    output logic                  m_last
);

    localparam int unsigned N = COORD_BITS;
    localparam int unsigned D = COORD_BITS + 4;
    localparam logic [N-1:0] ONE = {{(N-1){1'b0}}, 1'b1};

    // line state
    logic [N-1:0]    cur_x_reg;
    logic [N-1:0]    cur_y_reg;
    logic [N-1:0]    major_end_reg;
    logic [D-1:0]    decision_reg;
    logic [D-1:0]    inc_straight_reg;
    logic [D-1:0]    inc_diagonal_reg;
    logic            x_is_major_reg;
    logic            minor_neg_reg;
    logic            active_reg;

    // result register
    logic            out_valid_reg;
    logic [N-1:0]    out_x_reg;
    logic [N-1:0]    out_y_reg;
    logic [COLOR_BITS-1:0] out_color_reg;
    logic            out_pixel_valid_reg;
    logic            out_last_reg;

    // working values: a load takes the fresh setup, a step the stored line
    logic [N-1:0]    src_x;
    logic [N-1:0]    src_y;
    logic [N-1:0]    src_major_end;
    logic [D-1:0]    src_decision;
    logic [D-1:0]    src_inc_straight;
    logic [D-1:0]    src_inc_diagonal;
    logic            src_x_is_major;
    logic            src_minor_neg;
    logic            src_active;

    logic [N-1:0]    major;
    logic [N-1:0]    minor;
    logic [N-1:0]    major_next;
    logic [N-1:0]    minor_next;
    logic [D-1:0]    decision_next;
    logic            at_end;
    logic            advance;

    logic [N-1:0]    cur_x_next;
    logic [N-1:0]    cur_y_next;
    logic            active_next;

    assign q_ready = !out_valid_reg || m_ready;
    assign advance = q_valid && q_ready;

    always_comb begin
        if (q_ctl.is_load) begin
            src_x            = q_x;
            src_y            = q_y;
            src_major_end    = q_major_end;
            src_decision     = q_decision;
            src_inc_straight = q_inc_straight;
            src_inc_diagonal = q_inc_diagonal;
            src_x_is_major   = q_ctl.x_is_major;
            src_minor_neg    = q_ctl.minor_neg;
            src_active       = q_ctl.active;
        end else begin
            src_x            = cur_x_reg;
            src_y            = cur_y_reg;
            src_major_end    = major_end_reg;
            src_decision     = decision_reg;
            src_inc_straight = inc_straight_reg;
            src_inc_diagonal = inc_diagonal_reg;
            src_x_is_major   = x_is_major_reg;
            src_minor_neg    = minor_neg_reg;
            src_active       = active_reg;
        end

        major      = src_x_is_major ? src_x : src_y;
        minor      = src_x_is_major ? src_y : src_x;
        major_next = major + ONE;
        // negative decision keeps the minor coordinate
        if (src_decision[D-1]) begin
            minor_next    = minor;
            decision_next = src_decision + src_inc_straight;
        end else begin
            minor_next    = src_minor_neg ? (minor - ONE) : (minor + ONE);
            decision_next = src_decision + src_inc_diagonal;
        end
        at_end = (major_next == src_major_end);

        if (src_active) begin
            cur_x_next  = src_x_is_major ? major_next : minor_next;
            cur_y_next  = src_x_is_major ? minor_next : major_next;
            active_next = !at_end;
        end else begin
            cur_x_next    = src_x;
            cur_y_next    = src_y;
            active_next   = 1'b0;
            decision_next = src_decision;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            major_end_reg    <= '0;
            decision_reg     <= '0;
            inc_straight_reg <= '0;
            inc_diagonal_reg <= '0;
            x_is_major_reg   <= 1'b0;
            minor_neg_reg    <= 1'b0;
            active_reg       <= 1'b0;
        end else if (advance) begin
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            major_end_reg    <= src_major_end;
            decision_reg     <= decision_next;
            inc_straight_reg <= src_inc_straight;
            inc_diagonal_reg <= src_inc_diagonal;
            x_is_major_reg   <= src_x_is_major;
            minor_neg_reg    <= src_minor_neg;
            active_reg       <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_ready) begin
            out_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (src_active) begin
                out_x_reg           <= src_x;
                out_y_reg           <= src_y;
                out_color_reg       <= pixel_color;
                out_pixel_valid_reg <= 1'b1;
                out_last_reg        <= at_end;
            end else begin
                out_x_reg           <= '0;
                out_y_reg           <= '0;
                out_color_reg       <= '0;
                out_pixel_valid_reg <= 1'b0;
                out_last_reg        <= 1'b1;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_pixel_x     = out_x_reg;
    assign m_pixel_y     = out_y_reg;
    assign m_color       = out_color_reg;
    assign m_pixel_valid = out_pixel_valid_reg;
    assign m_last        = out_last_reg;

endmodule

`default_nettype wire
